>>> src/jsu_pkg.sv
// Shared types and codes for the JSON string unescape block.
// No dependencies; used by every module under src.

package jsu_pkg;

    localparam int RES_DEPTH = 8;
    localparam int MAX_RES = 3;

    localparam logic [1:0] RK_DATA   = 2'd0;
    localparam logic [1:0] RK_CLOSED = 2'd1;
    localparam logic [1:0] RK_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_CTRL      = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
    localparam logic [2:0] ERR_UNTERM    = 3'd5;
    localparam logic [2:0] ERR_UNTERM_ESC = 3'd6;
    localparam logic [2:0] ERR_SHORT_U   = 3'd7;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0]       cnt;
        res_t [MAX_RES-1:0] res;
    } dec_t;

endpackage

>>> src/jsu_decode.sv
// Per-byte decoder with the string phase, hex accumulator and digit count.
// Depends on jsu_pkg for result types and codes.

module jsu_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              kind,
    input  logic [7:0]        in_byte,
    output jsu_pkg::dec_t     dec
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     acc_reg, acc_next;
    logic [1:0]      cnt_reg, cnt_next;

    logic [4:0]  hex_d;
    logic [15:0] cp;
    logic [8:0]  esc;

    always_comb
    begin
        hex_d = 5'h10;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_d = {1'b0, in_byte[3:0]};
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
            hex_d = {1'b0, in_byte[3:0] + 4'd9};
    end

    always_comb
    begin
        case (in_byte)
            8'h22:   esc = {1'b1, 8'h22};
            8'h5C:   esc = {1'b1, 8'h5C};
            8'h2F:   esc = {1'b1, 8'h2F};
            8'h62:   esc = {1'b1, 8'h08};
            8'h66:   esc = {1'b1, 8'h0C};
            8'h6E:   esc = {1'b1, 8'h0A};
            8'h72:   esc = {1'b1, 8'h0D};
            8'h74:   esc = {1'b1, 8'h09};
            default: esc = 9'h000;
        endcase
    end

    assign cp = {acc_reg[11:0], hex_d[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        dec        = '0;
        case (phase_reg)
            jsu_pkg::PH_STR:
            begin
                if (kind)
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_ERROR;
                    dec.res[0].code = jsu_pkg::ERR_UNTERM;
                end
                else if (in_byte == 8'h22)
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_CLOSED;
                end
                else if (in_byte < 8'h20)
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_ERROR;
                    dec.res[0].code = jsu_pkg::ERR_CTRL;
                end
                else if (in_byte == 8'h5C)
                begin
                    phase_next = jsu_pkg::PH_ESC;
                end
                else
                begin
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_DATA;
                    dec.res[0].data = in_byte;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (kind)
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_ERROR;
                    dec.res[0].code = jsu_pkg::ERR_UNTERM_ESC;
                end
                else if (in_byte == 8'h75)
                begin
                    phase_next = jsu_pkg::PH_HEX;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else if (!esc[8])
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_ERROR;
                    dec.res[0].code = jsu_pkg::ERR_BAD_ESC;
                end
                else
                begin
                    phase_next = jsu_pkg::PH_STR;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_DATA;
                    dec.res[0].data = esc[7:0];
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (kind || hex_d[4])
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                    dec.cnt = 2'd1;
                    dec.res[0].kind = jsu_pkg::RK_ERROR;
                    dec.res[0].code = kind ? jsu_pkg::ERR_SHORT_U : jsu_pkg::ERR_BAD_HEX;
                end
                else
                begin
                    acc_next = cp;
                    if (cnt_reg == 2'd3)
                    begin
                        cnt_next   = '0;
                        phase_next = jsu_pkg::PH_STR;
                        dec.res[0].kind = jsu_pkg::RK_DATA;
                        dec.res[1].kind = jsu_pkg::RK_DATA;
                        dec.res[2].kind = jsu_pkg::RK_DATA;
                        if (cp <= 16'h007F)
                        begin
                            dec.cnt = 2'd1;
                            dec.res[0].data = cp[7:0];
                        end
                        else if (cp <= 16'h07FF)
                        begin
                            dec.cnt = 2'd2;
                            dec.res[0].data = 8'hC0 | {3'b000, cp[10:6]};
                            dec.res[1].data = 8'h80 | {2'b00, cp[5:0]};
                        end
                        else
                        begin
                            dec.cnt = 2'd3;
                            dec.res[0].data = 8'hE0 | {4'b0000, cp[15:12]};
                            dec.res[1].data = 8'h80 | {2'b00, cp[11:6]};
                            dec.res[2].data = 8'h80 | {2'b00, cp[5:0]};
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                phase_next = jsu_pkg::PH_WAIT;
                if (!kind)
                begin
                    if (in_byte == 8'h22)
                    begin
                        phase_next = jsu_pkg::PH_STR;
                    end
                    else
                    begin
                        dec.cnt = 2'd1;
                        dec.res[0].kind = jsu_pkg::RK_ERROR;
                        dec.res[0].code = jsu_pkg::ERR_NO_QUOTE;
                    end
                end
            end
        endcase
        case (dec.cnt)
            2'd1:    dec.res[0].last = 1'b1;
            2'd2:    dec.res[1].last = 1'b1;
            2'd3:    dec.res[2].last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsu_pkg::PH_WAIT;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/jsu_result_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on jsu_pkg for the result and bundle types.

module jsu_result_fifo
#(
    parameter int DEPTH = jsu_pkg::RES_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::dec_t dec,
    output logic          room,
    output logic          out_valid,
    input  logic          out_stall,
    output jsu_pkg::res_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    push_n;
    logic          pop;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] b, input logic [1:0] k);
        logic [PW:0] s;
        s = {1'b0, b} + (PW+1)'(k);
        if (s >= (PW+1)'(DEPTH))
            s = s - (PW+1)'(DEPTH);
        return s[PW-1:0];
    endfunction

    assign push_n    = push ? dec.cnt : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = mem_reg[rd_reg];
    assign room      = (cnt_reg <= CW'(DEPTH - jsu_pkg::MAX_RES));

    always_comb
    begin
        wr_next  = wrap_add(wr_reg, push_n);
        rd_next  = pop ? wrap_add(rd_reg, 2'd1) : rd_reg;
        cnt_next = cnt_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < jsu_pkg::MAX_RES; k++)
        begin
            if (2'(k) < push_n)
                mem_reg[wrap_add(wr_reg, 2'(k))] <= dec.res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> src/json_string_unescape_core.sv
// Top level of the JSON string unescape block: input register, decoder, result queue.
// Depends on jsu_pkg, jsu_decode and jsu_result_fifo.

// Decodes one quoted JSON string from a byte stream: one input transfer per cycle while
// in_stall is low, each giving zero to three results (a \u escape gives up to three
// UTF-8 bytes). An input transfer lands in an input register, is decoded once the result
// queue has room, and its results are written into the DEPTH-entry result queue. Results
// leave one per cycle while out_stall is low, so the input sustains one byte per cycle
// whenever the output keeps up, and in_stall rises only while the queue has fewer than
// three free entries with a byte waiting to be decoded.

module json_string_unescape_core
#(
    parameter int DEPTH = jsu_pkg::RES_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] out_byte,
    output logic [2:0] error_code,
    output logic       last
);

    logic          vld_reg, vld_next;
    logic          kind_reg;
    logic [7:0]    byte_reg;
    logic          room;
    logic          consume;
    logic          accept;
    jsu_pkg::dec_t dec;
    jsu_pkg::res_t head;

    assign consume  = vld_reg && room;
    assign in_stall = vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (consume)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            byte_reg <= in_byte;
        end
    end

    jsu_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (consume),
        .kind    (kind_reg),
        .in_byte (byte_reg),
        .dec     (dec)
    );

    jsu_result_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (consume),
        .dec       (dec),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign result_kind = head.kind;
    assign out_byte    = head.data;
    assign error_code  = head.code;
    assign last        = head.last;

    a_nondata_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != jsu_pkg::RK_DATA |-> out_byte == 8'h00)
        else $error("non-data result carries a byte");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != jsu_pkg::RK_ERROR |-> error_code == jsu_pkg::ERR_NONE)
        else $error("error code on non-error result");

    a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == jsu_pkg::RK_ERROR || result_kind == jsu_pkg::RK_CLOSED)
        |-> last)
        else $error("closed or error result not marked last");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> vld_reg && $stable(byte_reg) && $stable(kind_reg))
        else $error("input register changed while stalled");

endmodule
